// ===== src/lrct_pkg.sv =====
package lrct_pkg;

	localparam int CoordW  = 32;
	localparam int BasisW  = 21;
	localparam int RowW    = 3 * BasisW;
	localparam int VolW    = 40;
	localparam int NumRows = 3;
	localparam int CfgIdxW = 2;
	localparam int ProdW   = 2 * CoordW;
	localparam int AccW    = ProdW + 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_ROW_A = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ROW_B = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ROW_C = 2'd2;

	// operation codes
	localparam logic OP_TO_FRAC = 1'b0;
	localparam logic OP_TO_ABS  = 1'b1;

	typedef struct packed {
		logic              op;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [39:0] cell_volume;
		logic               status;
	} out_beat_t;

	typedef struct packed {
		logic               busy;
		logic               vol_zero;
		logic signed [39:0] volume;
	} eng_stat_t;

	// signed lattice component at column col of a packed row
	function automatic logic signed [BasisW-1:0] basis_fld(logic [RowW-1:0] row,
			logic [1:0] col);
		case (col)
			2'd0: basis_fld = row[BasisW-1:0];
			2'd1: basis_fld = row[2*BasisW-1:BasisW];
			default: basis_fld = row[RowW-1:2*BasisW];
		endcase
	endfunction

	// (i + 1) mod 3
	function automatic logic [1:0] next3(logic [1:0] i);
		case (i)
			2'd0: next3 = 2'd1;
			2'd1: next3 = 2'd2;
			default: next3 = 2'd0;
		endcase
	endfunction

endpackage

// ===== src/lattice_reciprocal_and_coord_transform.sv =====
// a beat passes the s1, s2, s3 and output registers on its way to out_valid
// throughput: one beat per cycle; stages advance independently under out_stall
// after reset and after any row write the reciprocal unit rebuilds the basis
// with the one bit-per-cycle divider over nine entries, which is skipped when the
// volume is zero; input is stalled meanwhile
// reset (arst_n low, asynchronous) restores unit rows and empties the pipeline
module lattice_reciprocal_and_coord_transform
	import lrct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_beat_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_beat_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [RowW-1:0]    cfg_data
);

	// lattice rows, reset to the unit cell
	logic [RowW-1:0] rows_q [NumRows];
	logic            cfg_wr;

	logic signed [CoordW-1:0] recip [3][3];
	eng_stat_t                eng_stat;

	// pipeline: s1 input, s2 products, s3 sums, then rounded output register
	logic                     v_s1, v_s2, v_s3;
	in_beat_t                 d_s1;
	logic                     op_s2, op_s3;
	logic signed [ProdW-1:0]  prod_s2 [3][3];
	logic signed [AccW-1:0]   sum_s3 [3];
	logic                     out_valid_q;
	out_beat_t                out_q;

	logic                     en1, en2, en3, en4;
	logic                     accept;
	logic signed [CoordW-1:0] crd [3];
	logic signed [ProdW-1:0]  prod [3][3];
	logic signed [AccW-1:0]   sum [3];
	logic signed [CoordW-1:0] res [3];

	// round half up by 12 (to Q8.24) or 24 (to Q20.12) bits, saturate to 32
	function automatic logic signed [CoordW-1:0] rnd_sat(logic signed [AccW-1:0] a,
			logic wide);
		logic signed [AccW-1:0] t;
		t = wide ? (a + AccW'(64'sd8388608)) >>> 24 : (a + AccW'(64'sd2048)) >>> 12;
		if ((&t[AccW-1:CoordW-1]) || !(|t[AccW-1:CoordW-1])) begin
			rnd_sat = t[CoordW-1:0];
		end else if (t[AccW-1]) begin
			rnd_sat = {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			rnd_sat = {1'b0, {(CoordW-1){1'b1}}};
		end
	endfunction

	// configuration: always ready, out-of-range index dropped
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready && (cfg_index <= CFG_ROW_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[CFG_ROW_A] <= RowW'(64'd4096);
			rows_q[CFG_ROW_B] <= RowW'(64'd4096) << BasisW;
			rows_q[CFG_ROW_C] <= RowW'(64'd4096) << (2 * BasisW);
		end else if (cfg_wr) begin
			rows_q[cfg_index] <= cfg_data;
		end
	end

	// volume and reciprocal basis
	lrct_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.rows   (rows_q),
		.recip  (recip),
		.stat   (eng_stat)
	);

	// per-stage enables: a stage moves when empty or when the next one moves
	assign en4 = !out_valid_q || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = eng_stat.busy || !en1;
	assign accept = in_valid && !in_stall;

	// nine products: reciprocal rows for op 0, basis columns for op 1
	always_comb begin
		crd[0] = d_s1.coord_x;
		crd[1] = d_s1.coord_y;
		crd[2] = d_s1.coord_z;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				if (d_s1.op == OP_TO_ABS) begin
					prod[j][k] = crd[k] * CoordW'(basis_fld(rows_q[k], 2'(j)));
				end else begin
					prod[j][k] = crd[k] * recip[j][k];
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum[j] = AccW'(prod_s2[j][0]) + AccW'(prod_s2[j][1]) + AccW'(prod_s2[j][2]);
		end
	end

	// zero volume leaves the reciprocal all zero, so op 0 rounds to zero here
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			res[j] = rnd_sat(sum_s3[j], op_s3 == OP_TO_ABS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && accept) begin
			d_s1 <= in_data;
		end
		if (en2 && v_s1) begin
			op_s2 <= d_s1.op;
			prod_s2 <= prod;
		end
		if (en3 && v_s2) begin
			op_s3 <= op_s2;
			sum_s3 <= sum;
		end
		if (en4 && v_s3) begin
			out_q.out_x <= res[0];
			out_q.out_y <= res[1];
			out_q.out_z <= res[2];
			out_q.cell_volume <= eng_stat.volume;
			out_q.status <= eng_stat.vol_zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_cfg_starts_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index <= CFG_ROW_C) |=> eng_stat.busy)
		else $error("row write did not start a rebuild");
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en3) |=> (v_s3 && $stable(sum_s3[0]) && $stable(op_s3)))
		else $error("stalled sum stage changed");
	a_zero_recip: assert property (@(posedge clk) disable iff (!arst_n)
		(!eng_stat.busy && eng_stat.vol_zero) |->
		(recip[0][0] == 0 && recip[0][1] == 0 && recip[0][2] == 0 &&
		 recip[1][0] == 0 && recip[1][1] == 0 && recip[1][2] == 0 &&
		 recip[2][0] == 0 && recip[2][1] == 0 && recip[2][2] == 0))
		else $error("zero volume with nonzero reciprocal");
`endif

endmodule

// ===== src/lrct_recip.sv =====
module lrct_recip
	import lrct_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr,
	input  logic [RowW-1:0]          rows [NumRows],
	output logic signed [CoordW-1:0] recip [3][3],
	output eng_stat_t                stat
);

	localparam int CofW     = 2 * BasisW + 1;
	localparam int MagW     = CofW - 1;
	localparam int NumW     = MagW + 36;
	localparam int MvW      = 64;
	localparam int DivSteps = NumW;
	localparam int CntW     = $clog2(DivSteps);
	localparam int QW       = 33;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_COF  = 7'b0000010,
		S_VOL  = 7'b0000100,
		S_VEND = 7'b0001000,
		S_LOAD = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_FIN  = 7'b1000000
	} eng_state_t;

	eng_state_t              state_q;
	logic                    dirty_q;
	logic [1:0]              ri_q, ci_q;
	logic [CntW-1:0]         cnt_q;
	logic signed [CofW-1:0]  cof_q [3][3];
	logic signed [AccW-1:0]  acc_q;
	logic signed [VolW-1:0]  volume_q;
	logic                    zero_q;
	logic [MvW-1:0]          mv_q;
	logic                    vneg_q;
	logic [NumW-1:0]         n_q;
	logic [MvW:0]            r_q;
	logic [QW-1:0]           q_q;
	logic                    big_q;
	logic                    cneg_q;
	logic signed [CoordW-1:0] recip_q [3][3];

	logic [1:0]              rj, rk, c1, c2;
	logic signed [BasisW-1:0] bj1, bk2, bj2, bk1, b0;
	logic signed [2*BasisW-1:0] p1, p2;
	logic signed [CofW-1:0]  cof_new, cof_cur;
	logic signed [MvW-1:0]   vp;
	logic signed [AccW-1:0]  vol_sh, acc_neg;
	logic signed [VolW-1:0]  vol_sat;
	logic [MagW-1:0]         mc;
	logic [MvW:0]            rs;
	logic                    ge;
	logic [QW:0]             qs, qr;
	logic                    rnd;
	logic signed [CoordW-1:0] entry;
	logic                    last_idx;

	assign rj = next3(ri_q);
	assign rk = next3(rj);
	assign c1 = next3(ci_q);
	assign c2 = next3(c1);

	// cofactor (cross product) lane: two narrow products a cycle
	always_comb begin
		bj1 = basis_fld(rows[rj], c1);
		bk2 = basis_fld(rows[rk], c2);
		bj2 = basis_fld(rows[rj], c2);
		bk1 = basis_fld(rows[rk], c1);
		p1 = bj1 * bk2;
		p2 = bj2 * bk1;
		cof_new = CofW'(p1) - CofW'(p2);
	end

	// triple product term
	always_comb begin
		b0 = basis_fld(rows[0], ci_q);
		vp = b0 * cof_q[0][ci_q];
	end

	// volume round half up to Q28.12 and saturate
	always_comb begin
		vol_sh = (acc_q + AccW'(64'sd8388608)) >>> 24;
		if ((&vol_sh[AccW-1:VolW-1]) || !(|vol_sh[AccW-1:VolW-1])) begin
			vol_sat = vol_sh[VolW-1:0];
		end else if (vol_sh[AccW-1]) begin
			vol_sat = {1'b1, {(VolW-1){1'b0}}};
		end else begin
			vol_sat = {1'b0, {(VolW-1){1'b1}}};
		end
		acc_neg = -acc_q;
	end

	always_comb begin
		cof_cur = cof_q[ri_q][ci_q];
		mc = cof_cur[CofW-1] ? MagW'(-cof_cur) : cof_cur[MagW-1:0];
	end

	// one restoring division step
	always_comb begin
		rs = {r_q[MvW-1:0], n_q[NumW-1]};
		ge = rs >= {1'b0, mv_q};
		qs = {q_q, ge};
	end

	// final rounding (half away from zero on magnitude) and saturation
	always_comb begin
		rnd = !big_q && ({r_q[MvW-1:0], 1'b0} >= {1'b0, mv_q});
		qr = {1'b0, q_q} + (QW+1)'(rnd);
		if (cneg_q ^ vneg_q) begin
			if (big_q || qr > (QW+1)'(34'h080000000)) begin
				entry = {1'b1, {(CoordW-1){1'b0}}};
			end else begin
				entry = CoordW'(-qr);
			end
		end else begin
			if (big_q || qr > (QW+1)'(34'h07FFFFFFF)) begin
				entry = {1'b0, {(CoordW-1){1'b1}}};
			end else begin
				entry = qr[CoordW-1:0];
			end
		end
	end

	assign last_idx = (ri_q == 2'd2) && (ci_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dirty_q <= 1'b1;
			ri_q <= 2'd0;
			ci_q <= 2'd0;
			cnt_q <= '0;
			zero_q <= 1'b0;
			volume_q <= '0;
		end else begin
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (dirty_q) begin
						if (!cfg_wr) begin
							dirty_q <= 1'b0;
						end
						ri_q <= 2'd0;
						ci_q <= 2'd0;
						state_q <= S_COF;
					end
				end
				S_COF: begin
					if (last_idx) begin
						ri_q <= 2'd0;
						ci_q <= 2'd0;
						state_q <= S_VOL;
					end else if (ci_q == 2'd2) begin
						ci_q <= 2'd0;
						ri_q <= ri_q + 2'd1;
					end else begin
						ci_q <= ci_q + 2'd1;
					end
				end
				S_VOL: begin
					if (ci_q == 2'd2) begin
						ci_q <= 2'd0;
						state_q <= S_VEND;
					end else begin
						ci_q <= ci_q + 2'd1;
					end
				end
				S_VEND: begin
					zero_q <= (acc_q == '0);
					volume_q <= vol_sat;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q <= '0;
					if (zero_q) begin
						if (last_idx) begin
							state_q <= S_IDLE;
						end else if (ci_q == 2'd2) begin
							ci_q <= 2'd0;
							ri_q <= ri_q + 2'd1;
						end else begin
							ci_q <= ci_q + 2'd1;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (last_idx) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOAD;
						if (ci_q == 2'd2) begin
							ci_q <= 2'd0;
							ri_q <= ri_q + 2'd1;
						end else begin
							ci_q <= ci_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_COF: cof_q[ri_q][ci_q] <= cof_new;
			S_VOL: acc_q <= acc_q + AccW'(vp);
			S_VEND: begin
				vneg_q <= acc_q[AccW-1];
				mv_q <= acc_q[AccW-1] ? acc_neg[MvW-1:0] : acc_q[MvW-1:0];
			end
			S_LOAD: begin
				n_q <= {mc, 36'd0};
				r_q <= '0;
				q_q <= '0;
				big_q <= 1'b0;
				cneg_q <= cof_cur[CofW-1];
				if (zero_q) begin
					recip_q[ri_q][ci_q] <= '0;
				end
			end
			S_DIV: begin
				r_q <= ge ? rs - {1'b0, mv_q} : rs;
				n_q <= {n_q[NumW-2:0], 1'b0};
				q_q <= qs[QW-1:0];
				big_q <= big_q | qs[QW];
			end
			S_FIN: recip_q[ri_q][ci_q] <= entry;
			default: ;
		endcase
	end

	assign recip = recip_q;
	assign stat.busy = dirty_q || (state_q != S_IDLE);
	assign stat.vol_zero = zero_q;
	assign stat.volume = volume_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (r_q < {1'b0, mv_q}))
		else $error("division remainder not below divisor");
	a_no_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !zero_q)
		else $error("division started on zero volume");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("engine state not one-hot");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
	import lrct_pkg::*;

	// watchdog: cycles with no beat on any channel before the run is called hung
	localparam int HangLimit = 20000;
	localparam int ItemTarget = 1550;
	// items past this count run with no idling on either side
	localparam int CalmFrom = 1400;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_beat_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_beat_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [RowW-1:0]    cfg_data;

	lattice_reciprocal_and_coord_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// lattice state as the block should hold it
	logic [RowW-1:0]    lat_rows [NumRows];
	int                 recip_q [9];      // reciprocal basis, q8.24
	logic signed [39:0] vol_q;            // rounded cell volume, q28.12
	bit                 vol_zero;         // exact volume is zero
	bit                 recip_ok;         // reciprocal basis current

	out_beat_t pending_results[$];        // results still owed by the block
	int        n_err;
	int        n_items;
	bit        calm;                      // no idling on either side
	int        stall_left;

	// ------------------------------------------------------------------
	// arithmetic helpers
	// ------------------------------------------------------------------

	// round half up by s bits then clamp to a signed value of w bits
	function automatic logic signed [127:0] round_clamp(logic signed [127:0] a, int s, int w);
		logic signed [127:0] t;
		logic signed [127:0] hi;
		t = (a + (128'sd1 <<< (s - 1))) >>> s;
		hi = (128'sd1 <<< (w - 1)) - 1;
		if (t > hi) return hi;
		if (t < -hi - 1) return -hi - 1;
		return t;
	endfunction

	function automatic longint lat_comp(int r, int c);
		logic signed [BasisW-1:0] f;
		f = lat_rows[r][BasisW*c +: BasisW];
		return longint'(f);
	endfunction

	// cofactor * 2^36 / volume in q8.24, magnitude rounded half away from zero
	function automatic int recip_entry(longint c, longint v);
		logic [63:0]  mc;
		logic [63:0]  mv;
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] r;
		bit           big;
		mc = (c < 0) ? 64'(-c) : 64'(c);
		mv = (v < 0) ? 64'(-v) : 64'(v);
		num = {64'd0, mc} << 36;
		q = num / {64'd0, mv};
		r = num % {64'd0, mv};
		big = q >= (128'd1 << 33);
		if (!big && r >= {64'd0, mv} - r) q = q + 1;
		if ((c < 0) != (v < 0)) begin
			if (big || q > 128'h80000000) return 32'h80000000;
			return -int'(q[31:0]);
		end
		if (big || q > 128'h7FFFFFFF) return 32'h7FFFFFFF;
		return int'(q[31:0]);
	endfunction

	// expected result for one atom; rebuilds the reciprocal basis when stale
	function automatic out_beat_t convert_atom(in_beat_t a);
		longint              b [3][3];
		longint              cof [3][3];
		longint              c [3];
		longint              vol;
		logic signed [127:0] acc;
		logic signed [127:0] r;
		out_beat_t           res;
		int                  j;
		int                  k;
		if (!recip_ok) begin
			for (int i = 0; i < 3; i++)
				for (int m = 0; m < 3; m++)
					b[i][m] = lat_comp(i, m);
			for (int i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				k = (i + 2) % 3;
				cof[i][0] = b[j][1] * b[k][2] - b[j][2] * b[k][1];
				cof[i][1] = b[j][2] * b[k][0] - b[j][0] * b[k][2];
				cof[i][2] = b[j][0] * b[k][1] - b[j][1] * b[k][0];
			end
			acc = 0;
			for (int i = 0; i < 3; i++) acc = acc + b[0][i] * cof[0][i];
			vol = acc[63:0];
			vol_q = 40'(round_clamp(acc, 24, 40));
			vol_zero = (vol == 0);
			for (int i = 0; i < 9; i++)
				recip_q[i] = vol_zero ? 0 : recip_entry(cof[i / 3][i % 3], vol);
			recip_ok = 1;
		end
		c[0] = longint'(a.coord_x);
		c[1] = longint'(a.coord_y);
		c[2] = longint'(a.coord_z);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			if (a.op == OP_TO_FRAC) begin
				for (int m = 0; m < 3; m++) acc = acc + c[m] * longint'(recip_q[i*3 + m]);
				r = vol_zero ? 0 : round_clamp(acc, 12, 32);
			end else begin
				for (int m = 0; m < 3; m++) acc = acc + c[m] * lat_comp(m, i);
				r = round_clamp(acc, 24, 32);
			end
			case (i)
				0: res.out_x = r[31:0];
				1: res.out_y = r[31:0];
				default: res.out_z = r[31:0];
			endcase
		end
		res.cell_volume = vol_q;
		res.status = vol_zero;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [RowW-1:0] pack_row(int x, int y, int z);
		return {BasisW'(z), BasisW'(y), BasisW'(x)};
	endfunction

	function automatic in_beat_t atom(logic op, int x, int y, int z);
		in_beat_t a;
		a.op = op;
		a.coord_x = x;
		a.coord_y = y;
		a.coord_z = z;
		return a;
	endfunction

	function automatic int rnd_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return int'($urandom_range(0, 1 << 17)) - (1 << 16);
			2: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	function automatic int rnd_field();
		case ($urandom_range(0, 3))
			0: return (1 << 20) - 1;    // largest positive component
			1: return -(1 << 20);       // most negative component
			2: return 0;
			default: return 1;
		endcase
	endfunction

	function automatic logic [RowW-1:0] rnd_row();
		int s;
		s = 8 * 4096;
		case ($urandom_range(0, 7))
			0: return lat_rows[$urandom_range(0, 2)];  // parallel rows, flat cell
			1: return '0;
			2: return pack_row(rnd_field(), rnd_field(), rnd_field());
			3, 4: return RowW'({$urandom, $urandom});
			default: return pack_row(int'($urandom_range(0, 2 * s)) - s,
					int'($urandom_range(0, 2 * s)) - s, int'($urandom_range(0, 2 * s)) - s);
		endcase
	endfunction

	// one input beat; a typed expectation replaces the predicted one when given
	task automatic send_atom(in_beat_t a, bit has_exp, out_beat_t exp_res);
		int        gap;
		out_beat_t want;
		gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = a;
		do @(posedge clk); while (in_stall);
		want = convert_atom(a);
		pending_results.push_back(has_exp ? exp_res : want);
		n_items++;
	endtask

	// drain the pipeline and let the block go quiet before a row write
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_row(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		// out-of-range indexes leave the rows and the basis alone
		if (idx <= CFG_ROW_C) begin
			lat_rows[idx] = val;
			recip_ok = 0;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------

	typedef struct {
		bit                 is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [RowW-1:0]    val;
		in_beat_t           a;
		bit                 has_exp;
		out_beat_t          exp_res;
	} stim_row_t;

	stim_row_t plan[$];

	function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] val);
		stim_row_t s;
		s = '{default: '0};
		s.is_cfg = 1;
		s.idx = idx;
		s.val = val;
		plan.push_back(s);
	endfunction

	function automatic void add_atom(in_beat_t a);
		stim_row_t s;
		s = '{default: '0};
		s.a = a;
		plan.push_back(s);
	endfunction

	function automatic void add_atom_exp(in_beat_t a, out_beat_t e);
		stim_row_t s;
		s = '{default: '0};
		s.a = a;
		s.has_exp = 1;
		s.exp_res = e;
		plan.push_back(s);
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, receiver side
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// random stall bursts on the result side, none once the run is calm
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			out_stall = 1'b1;
			stall_left = $urandom_range(1, 18) - 1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// result checker: every result beat against the oldest expectation
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				n_err++;
			end else begin
				e = pending_results.pop_front();
				if (out_data.out_x !== e.out_x) begin
					$error("out_x exp %0d got %0d", e.out_x, out_data.out_x);
					n_err++;
				end
				if (out_data.out_y !== e.out_y) begin
					$error("out_y exp %0d got %0d", e.out_y, out_data.out_y);
					n_err++;
				end
				if (out_data.out_z !== e.out_z) begin
					$error("out_z exp %0d got %0d", e.out_z, out_data.out_z);
					n_err++;
				end
				if (out_data.cell_volume !== e.cell_volume) begin
					$error("cell_volume exp %0d got %0d", e.cell_volume, out_data.cell_volume);
					n_err++;
				end
				if (out_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_data.status);
					n_err++;
				end
			end
		end
	end

	// watchdog: a long stretch with no beat anywhere means a hang
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= HangLimit) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		int n_phase;
		int n_wr;
		out_beat_t z;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROW_A;
		cfg_data = '0;
		stall_left = 0;
		quiet_cycles = 0;
		n_err = 0;
		n_items = 0;
		calm = 0;
		// unit cell after reset
		lat_rows[CFG_ROW_A] = pack_row(4096, 0, 0);
		lat_rows[CFG_ROW_B] = pack_row(0, 4096, 0);
		lat_rows[CFG_ROW_C] = pack_row(0, 0, 4096);
		recip_ok = 0;
		vol_q = '0;
		vol_zero = 0;
		for (int i = 0; i < 9; i++) recip_q[i] = 0;

		// unit cell: fractional and absolute coincide, volume 1.0
		add_atom_exp(atom(OP_TO_FRAC, 4096, 0, 0),
				'{32'sd16777216, 32'sd0, 32'sd0, 40'sd4096, 1'b0});
		// absolute extremes saturate in q8.24
		add_atom_exp(atom(OP_TO_FRAC, 32'h7FFFFFFF, 32'h80000000, 0),
				'{32'h7FFFFFFF, 32'h80000000, 32'sd0, 40'sd4096, 1'b0});
		add_atom_exp(atom(OP_TO_ABS, 1 << 24, -(1 << 24), 0),
				'{32'sd4096, -32'sd4096, 32'sd0, 40'sd4096, 1'b0});
		// fractional extremes, and -1 lsb rounding up to zero
		add_atom_exp(atom(OP_TO_ABS, 32'h7FFFFFFF, 32'h80000000, -1),
				'{32'sd524288, -32'sd524288, 32'sd0, 40'sd4096, 1'b0});
		add_atom(atom(OP_TO_FRAC, -1, 1, 2048));
		// flat cell: third row zero, volume zero
		add_cfg(CFG_ROW_C, '0);
		add_atom_exp(atom(OP_TO_FRAC, 12345, -5, 7), '{32'sd0, 32'sd0, 32'sd0, 40'sd0, 1'b1});
		add_atom(atom(OP_TO_ABS, 1 << 24, 1 << 24, 1 << 24));
		// extreme components in every row
		add_cfg(CFG_ROW_A, pack_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
		add_cfg(CFG_ROW_B, pack_row(-(1 << 20), -(1 << 20), -(1 << 20)));
		add_cfg(CFG_ROW_C, pack_row(-(1 << 20), 1, 20'hFFFFF));
		add_atom(atom(OP_TO_FRAC, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
		add_atom(atom(OP_TO_ABS, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		add_atom(atom(OP_TO_FRAC, 1, -1, 0));
		// write to an index past the last row is dropped
		add_cfg(2'd3, RowW'(64'h5A5A_5A5A_5A5A_5A5A));
		add_atom(atom(OP_TO_ABS, 4096, -4096, 1));
		// one-lsb cell: nonzero volume that rounds to zero, status stays clear
		add_cfg(CFG_ROW_A, pack_row(1, 0, 0));
		add_cfg(CFG_ROW_B, pack_row(0, 1, 0));
		add_cfg(CFG_ROW_C, pack_row(0, 0, 1));
		add_atom(atom(OP_TO_FRAC, 1, 2, 3));
		add_atom(atom(OP_TO_ABS, 32'h7FFFFFFF, 1 << 24, -(1 << 24)));
		// skewed cell with negative volume
		add_cfg(CFG_ROW_A, pack_row(0, 2 * 4096, 0));
		add_cfg(CFG_ROW_B, pack_row(3 * 4096, 0, 0));
		add_cfg(CFG_ROW_C, pack_row(1024, -2048, 5 * 4096));
		add_atom(atom(OP_TO_FRAC, 4096, 8192, -12288));
		add_atom(atom(OP_TO_ABS, 1 << 23, -(1 << 22), 3 << 24));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_row(plan[i].idx, plan[i].val);
			end else begin
				send_atom(plan[i].a, plan[i].has_exp, plan[i].exp_res);
			end
		end

		// random phases: a new cell, then a run of atoms against it
		z = '0;
		n_phase = 0;
		while (n_items < ItemTarget) begin
			settle();
			n_wr = (n_phase % 4 == 0) ? 3 : $urandom_range(1, 3);
			for (int w = 0; w < n_wr; w++)
				write_row((n_wr == 3) ? w[1:0] : 2'($urandom_range(0, 3)), rnd_row());
			repeat ($urandom_range(40, 140)) begin
				calm = n_items >= CalmFrom;
				send_atom(atom(1'($urandom), rnd_coord(), rnd_coord(), rnd_coord()), 0, z);
			end
			n_phase++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (n_err == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
